// ===== rtl/galvo_spiral_scan_generator_defines.svh =====
// Assertion helpers shared by the scan generator RTL.
`ifndef GALVO_SPIRAL_SCAN_GENERATOR_DEFINES_SVH
`define GALVO_SPIRAL_SCAN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scan generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scan generator check failed");

`endif

// ===== rtl/gssg_pkg.sv =====
package gssg_pkg;

    // Register reset values
    localparam logic [11:0] RADIUS_STEP_RESET = 12'd100;
    localparam logic [14:0] MAX_RADIUS_RESET  = 15'd16383;
    localparam logic [15:0] CENTER_RESET      = 16'd32767;

    // Default circle resolution
    localparam int POINTS_PER_CIRCLE_DEFAULT = 360;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS_STEP = 2'd0,
        REG_MAX_RADIUS  = 2'd1,
        REG_CENTER_X    = 2'd2,
        REG_CENTER_Y    = 2'd3
    } cfg_reg_t;

    // Laser color codes
    typedef enum logic [1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2
    } color_t;

    // Q30 Taylor coefficients of sin(pi/2 * x)
    localparam longint unsigned COEF1 = 64'd1686629713;
    localparam longint unsigned COEF3 = 64'd693598668;
    localparam longint unsigned COEF5 = 64'd85569306;
    localparam longint unsigned COEF7 = 64'd5026995;
    localparam longint unsigned COEF9 = 64'd172272;

    // Quarter-wave sine of a Q16 fraction of a quarter turn, Q1.15 result.
    // Used at elaboration to build the trig tables.
    function automatic logic [15:0] quarter_sine(input logic [16:0] t);
        longint unsigned tt;
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned v;
        longint unsigned q;
        tt  = 64'(t);
        t2  = (tt * tt) >> 16;
        acc = COEF9;
        acc = COEF7 - ((acc * t2) >> 16);
        acc = COEF5 - ((acc * t2) >> 16);
        acc = COEF3 - ((acc * t2) >> 16);
        acc = COEF1 - ((acc * t2) >> 16);
        v   = (acc * tt) >> 16;
        q   = (v + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

endpackage

// ===== rtl/galvo_spiral_scan_generator.sv =====
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | s_valid, s_ready, s_restart             | in
// result   | m_valid, m_ready, m_x_code,             | out
//          | m_x_code_inverse, m_y_code,             |
//          | m_y_code_inverse, m_color, m_circle_end |
// config   | cfg_wr_en, cfg_addr, cfg_wr_data        | in
//
// One transaction in, one transaction out; a new point is taken every cycle while s_ready
// is high. The trig ROM read and pattern state update go into the input register,
// then radius-by-trig products, truncation, center add and saturation into the output.
// Each stage has its own valid bit and loads when empty or draining, so the input
// stalls only once a finished point waits at the output and the input stage is full.
// aresetn (synchronous, active low) restores registers and pattern state and
// empties the pipeline; the trig tables are constant ROMs and need no fill.
`include "galvo_spiral_scan_generator_defines.svh"

module galvo_spiral_scan_generator
    import gssg_pkg::*;
#(
    parameter int POINTS_PER_CIRCLE = POINTS_PER_CIRCLE_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_restart,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_x_code,
    output logic [15:0] m_x_code_inverse,
    output logic [15:0] m_y_code,
    output logic [15:0] m_y_code_inverse,
    output logic [1:0]  m_color,
    output logic        m_circle_end
);

    localparam int IDX_W = $clog2(POINTS_PER_CIRCLE);
    localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(POINTS_PER_CIRCLE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_CIRCLE - 1);

    typedef logic [POINTS_PER_CIRCLE-1:0][15:0] rom_t;

    // Build one Q1.15 table, sine or cosine, from the quarter-wave polynomial
    function automatic rom_t build_rom(input bit want_sine);
        rom_t            rom;
        longint unsigned u;
        longint unsigned quad;
        longint unsigned t;
        logic [15:0]     a;
        logic [15:0]     b;
        logic [15:0]     s;
        logic [15:0]     c;
        for (int k = 0; k < POINTS_PER_CIRCLE; k++) begin
            u    = 64'(4 * k);
            quad = (u / POINTS_PER_CIRCLE) % 4;
            t    = ((u % POINTS_PER_CIRCLE) * 64'd65536) / POINTS_PER_CIRCLE;
            a    = quarter_sine(17'(t));
            b    = quarter_sine(17'(64'd65536 - t));
            case (quad[1:0])
                2'd0: begin
                    s = a;
                    c = b;
                end
                2'd1: begin
                    s = b;
                    c = 16'(-a);
                end
                2'd2: begin
                    s = 16'(-a);
                    c = 16'(-b);
                end
                default: begin
                    s = 16'(-b);
                    c = a;
                end
            endcase
            rom[k] = want_sine ? s : c;
        end
        return rom;
    endfunction

    localparam rom_t SIN_ROM = build_rom(1'b1);
    localparam rom_t COS_ROM = build_rom(1'b0);

    // Truncate a Q15 product toward zero, add the center, clamp to DAC range
    function automatic logic [15:0] place(input logic [15:0] center,
                                          input logic signed [32:0] p);
        logic signed [32:0] biased;
        logic signed [17:0] off;
        logic signed [18:0] sum;
        logic [15:0]        code;
        biased = p + $signed({18'd0, {15{p[32]}}});
        off    = biased[32:15];
        sum    = $signed({3'b000, center}) + 19'(off);
        if (sum[18]) begin
            code = 16'h0000;
        end else if (sum[17:16] != 2'b00) begin
            code = 16'hFFFF;
        end else begin
            code = sum[15:0];
        end
        return code;
    endfunction

    // Configuration registers
    logic [11:0] radius_step_reg;
    logic [14:0] max_radius_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;

    // Pattern state
    logic [IDX_W-1:0]   angle_reg, angle_next;
    logic signed [16:0] radius_reg, radius_next;
    logic               outward_reg, outward_next;
    color_t             color_reg, color_next;

    // Pipeline valid bits and handshake chain
    logic va_reg, vc_reg;
    logic rdy_a, rdy_c;
    logic accept;

    // Stage A payload
    logic signed [15:0] cos_a_reg, sin_a_reg;
    logic signed [16:0] radius_a_reg;
    color_t             color_a_reg;
    logic               last_a_reg;

    // Radius-by-trig products of the point in stage A
    logic signed [32:0] prod_x, prod_y;

    // Stage C (output) payload
    logic [15:0] x_code_reg, y_code_reg;
    color_t      color_c_reg;
    logic        last_c_reg;

    // Effective state of the accepted point
    logic [IDX_W-1:0]   eff_angle;
    logic signed [16:0] eff_radius;
    logic               eff_outward;
    color_t             eff_color;
    logic               eff_last;
    logic signed [16:0] stepped;
    logic signed [16:0] step_ext;
    logic signed [16:0] max_ext;
    logic               flip;

    // Ready flows back through each stage that is empty or draining
    assign rdy_c   = !vc_reg || m_ready;
    assign rdy_a   = !va_reg || rdy_c;
    assign s_ready = rdy_a;
    assign accept  = s_valid && s_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_step_reg <= RADIUS_STEP_RESET;
            max_radius_reg  <= MAX_RADIUS_RESET;
            center_x_reg    <= CENTER_RESET;
            center_y_reg    <= CENTER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RADIUS_STEP: radius_step_reg <= cfg_wr_data[11:0];
                REG_MAX_RADIUS:  max_radius_reg  <= cfg_wr_data[14:0];
                REG_CENTER_X:    center_x_reg    <= cfg_wr_data;
                REG_CENTER_Y:    center_y_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Apply restart, step the angle, and at the circle end step the radius and flip at a bound
    always_comb begin
        step_ext = $signed({5'd0, radius_step_reg});
        max_ext  = $signed({2'b00, max_radius_reg});
        if (s_restart || ({1'b0, angle_reg} >= N_EXT)) begin
            eff_angle = '0;
        end else begin
            eff_angle = angle_reg;
        end
        eff_radius  = s_restart ? max_ext : radius_reg;
        eff_outward = s_restart ? 1'b0 : outward_reg;
        eff_color   = s_restart ? COLOR_RED : color_reg;
        eff_last    = (eff_angle == LAST_IDX);

        if (eff_outward) begin
            stepped = eff_radius + step_ext;
            flip    = (stepped >= max_ext);
        end else begin
            stepped = eff_radius - step_ext;
            flip    = (stepped <= 17'sd0);
        end

        angle_next   = eff_angle + IDX_W'(1);
        radius_next  = eff_radius;
        outward_next = eff_outward;
        color_next   = eff_color;
        if (eff_last) begin
            angle_next  = '0;
            radius_next = stepped;
            if (flip) begin
                outward_next = !eff_outward;
                case (eff_color)
                    COLOR_RED:   color_next = COLOR_GREEN;
                    COLOR_GREEN: color_next = COLOR_BLUE;
                    default:     color_next = COLOR_RED;
                endcase
            end
        end
    end

    // Advance pattern state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg   <= '0;
            radius_reg  <= $signed({2'b00, MAX_RADIUS_RESET});
            outward_reg <= 1'b0;
            color_reg   <= COLOR_RED;
        end else if (accept) begin
            angle_reg   <= angle_next;
            radius_reg  <= radius_next;
            outward_reg <= outward_next;
            color_reg   <= color_next;
        end
    end

    // Valid bits of the two stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= s_valid;
            end
            if (rdy_c) begin
                vc_reg <= va_reg;
            end
        end
    end

    // Stage A: registered trig ROM read and point attributes
    always_ff @(posedge aclk) begin
        if (accept) begin
            cos_a_reg    <= $signed(COS_ROM[eff_angle]);
            sin_a_reg    <= $signed(SIN_ROM[eff_angle]);
            radius_a_reg <= eff_radius;
            color_a_reg  <= eff_color;
            last_a_reg   <= eff_last;
        end
    end

    // Radius times cosine and sine
    assign prod_x = 33'(radius_a_reg) * 33'(cos_a_reg);
    assign prod_y = 33'(radius_a_reg) * 33'(sin_a_reg);

    // Stage C: round toward zero, offset by center, saturate
    always_ff @(posedge aclk) begin
        if (rdy_c && va_reg) begin
            x_code_reg  <= place(center_x_reg, prod_x);
            y_code_reg  <= place(center_y_reg, prod_y);
            color_c_reg <= color_a_reg;
            last_c_reg  <= last_a_reg;
        end
    end

    assign m_valid          = vc_reg;
    assign m_x_code         = x_code_reg;
    assign m_x_code_inverse = ~x_code_reg;
    assign m_y_code         = y_code_reg;
    assign m_y_code_inverse = ~y_code_reg;
    assign m_color          = color_c_reg;
    assign m_circle_end     = last_c_reg;

    // An empty output stage leaves the whole pipe able to take a transaction
    `GSSG_ASSERT_IMPLIES(a_empty_out_ready, aclk, aresetn, !vc_reg, s_ready)
    // The angle never leaves the circle
    `GSSG_ASSERT_IMPLIES(a_angle_range, aclk, aresetn, 1'b1, angle_reg <= LAST_IDX)
    // A restart emits the first point and moves on to the second
    `GSSG_ASSERT_NEXT(a_restart_angle, aclk, aresetn, accept && s_restart,
                      angle_reg == IDX_W'(1))
    // The last point of a circle wraps the angle
    `GSSG_ASSERT_NEXT(a_circle_wrap, aclk, aresetn,
                      accept && !s_restart && (angle_reg == LAST_IDX), angle_reg == '0)

endmodule

// ===== tb/sv/tb_galvo_spiral_scan_generator.sv =====
module tb_galvo_spiral_scan_generator
    import gssg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_POINTS     = 360;
    localparam int  PIPE_LATENCY = 2;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  REPORT_LIMIT = 10;

    // Q30 coefficients of the odd Taylor series of sin(pi/2 * f)
    localparam longint unsigned TAYLOR_C1 = 64'd1686629713;
    localparam longint unsigned TAYLOR_C3 = 64'd693598668;
    localparam longint unsigned TAYLOR_C5 = 64'd85569306;
    localparam longint unsigned TAYLOR_C7 = 64'd5026995;
    localparam longint unsigned TAYLOR_C9 = 64'd172272;

    typedef struct packed {
        logic [15:0] x_code;
        logic [15:0] x_code_inverse;
        logic [15:0] y_code;
        logic [15:0] y_code_inverse;
        logic [1:0]  color;
        logic        circle_end;
    } scan_point_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = 2'd0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_restart   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_x_code;
    logic [15:0] m_x_code_inverse;
    logic [15:0] m_y_code;
    logic [15:0] m_y_code_inverse;
    logic [1:0]  m_color;
    logic        m_circle_end;

    // Trig tables and predicted pattern state
    int          cos_lut [N_POINTS];
    int          sin_lut [N_POINTS];
    int unsigned step_reg;
    int unsigned max_radius_reg;
    int unsigned center_x_reg;
    int unsigned center_y_reg;
    int unsigned scan_angle;
    int          scan_radius;
    bit          scan_outward;
    color_t      scan_color;

    bit          restart_queue [$];
    scan_point_t expected_points [$];
    int          points_queued   = 0;
    int          points_accepted = 0;
    int          fail_count      = 0;
    int          cycle_count     = 0;
    int          send_idle_max   = 0;
    int          recv_idle_max   = 0;
    int          send_gap        = 0;
    int          recv_wait       = 0;
    int          stall_budget    = 0;
    int          stall_done      = 0;

    galvo_spiral_scan_generator #(
        .POINTS_PER_CIRCLE (N_POINTS)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_x_code         (m_x_code),
        .m_x_code_inverse (m_x_code_inverse),
        .m_y_code         (m_y_code),
        .m_y_code_inverse (m_y_code_inverse),
        .m_color          (m_color),
        .m_circle_end     (m_circle_end)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Sine over a quarter turn; frac is a Q16 fraction of that quarter
    function automatic int quarter_wave_q15(longint unsigned frac);
        longint unsigned sq;
        longint unsigned poly;
        longint unsigned prod;
        longint unsigned rounded;
        sq   = (frac * frac) >> 16;
        poly = TAYLOR_C9;
        poly = TAYLOR_C7 - ((poly * sq) >> 16);
        poly = TAYLOR_C5 - ((poly * sq) >> 16);
        poly = TAYLOR_C3 - ((poly * sq) >> 16);
        poly = TAYLOR_C1 - ((poly * sq) >> 16);
        prod    = (poly * frac) >> 16;
        rounded = (prod + 64'd16384) >> 15;
        if (rounded > 64'd32767) begin
            rounded = 64'd32767;
        end
        return int'(rounded);
    endfunction

    // Center plus radius*trig, offset truncated toward zero, clamped to DAC range
    function automatic logic [15:0] deflect(int unsigned center, int radius, int trig);
        longint prod;
        longint offset;
        longint sum;
        prod = longint'(radius) * longint'(trig);
        if (prod < 0) begin
            offset = -((-prod) >>> 15);
        end else begin
            offset = prod >>> 15;
        end
        sum = longint'(center) + offset;
        if (sum < 0) begin
            sum = 0;
        end else if (sum > 65535) begin
            sum = 65535;
        end
        return sum[15:0];
    endfunction

    // Emit the point for one transaction and advance angle, radius and color
    function automatic scan_point_t next_scan_point(bit restart);
        scan_point_t pt;
        bit          flip;
        if (restart) begin
            scan_angle   = 0;
            scan_radius  = int'(max_radius_reg);
            scan_outward = 1'b0;
            scan_color   = COLOR_RED;
        end
        if (scan_angle >= N_POINTS) begin
            scan_angle = 0;
        end
        pt.x_code         = deflect(center_x_reg, scan_radius, cos_lut[scan_angle]);
        pt.y_code         = deflect(center_y_reg, scan_radius, sin_lut[scan_angle]);
        pt.x_code_inverse = 16'hFFFF - pt.x_code;
        pt.y_code_inverse = 16'hFFFF - pt.y_code;
        pt.color          = scan_color;
        pt.circle_end     = (scan_angle == N_POINTS - 1);
        if (pt.circle_end) begin
            scan_angle = 0;
            if (!scan_outward) begin
                scan_radius = scan_radius - int'(step_reg);
                flip        = (scan_radius <= 0);
            end else begin
                scan_radius = scan_radius + int'(step_reg);
                flip        = (scan_radius >= int'(max_radius_reg));
            end
            if (flip) begin
                scan_outward = !scan_outward;
                scan_color   = (scan_color >= COLOR_BLUE) ? COLOR_RED : color_t'(scan_color + 1);
            end
        end else begin
            scan_angle++;
        end
        return pt;
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_RADIUS_STEP: step_reg       = value[11:0];
            REG_MAX_RADIUS:  max_radius_reg = value[14:0];
            REG_CENTER_X:    center_x_reg   = value;
            REG_CENTER_Y:    center_y_reg   = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue points; restart_odds of N gives a restart about once in N points
    task automatic queue_points(int count, bit lead_restart, int restart_odds);
        for (int i = 0; i < count; i++) begin
            if (i == 0 && lead_restart) begin
                restart_queue.push_back(1'b1);
            end else if (restart_odds > 0) begin
                restart_queue.push_back($urandom_range(0, restart_odds - 1) == 0);
            end else begin
                restart_queue.push_back(1'b0);
            end
            points_queued++;
        end
    endtask

    // Wait until every point is out, then let the pipeline settle
    task automatic wait_idle();
        while (points_accepted != points_queued || expected_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // Abort on a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Driver: offer queued points, with a random gap after each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_points.push_back(next_scan_point(s_restart));
                points_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (restart_queue.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_restart <= restart_queue.pop_front();
                    send_gap  <= $urandom_range(0, send_idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random
    always @(posedge aclk) begin
        scan_point_t got;
        scan_point_t want;
        int          wait_draw;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            got = {m_x_code, m_x_code_inverse, m_y_code, m_y_code_inverse,
                   m_color, m_circle_end};
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected point: x=%0d y=%0d color=%0d end=%0d",
                                 got.x_code, got.y_code, got.color, got.circle_end);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("point mismatch: expected x=%0d xi=%0d y=%0d yi=%0d c=%0d e=%0d",
                                     want.x_code, want.x_code_inverse, want.y_code,
                                     want.y_code_inverse, want.color, want.circle_end);
                            $display("                actual   x=%0d xi=%0d y=%0d yi=%0d c=%0d e=%0d",
                                     got.x_code, got.x_code_inverse, got.y_code,
                                     got.y_code_inverse, got.color, got.circle_end);
                        end
                    end
                end
            end
            // hold off for a long stretch when asked, else a random wait per result
            if (stall_done < stall_budget) begin
                stall_done <= stall_done + 1;
                m_ready    <= 1'b0;
            end else if (m_valid && m_ready) begin
                wait_draw = $urandom_range(0, recv_idle_max);
                recv_wait <= wait_draw;
                m_ready   <= (wait_draw == 0);
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_ready   <= (recv_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Build tables, reset, then run directed and random phases
    initial begin
        int unsigned quad;
        longint unsigned frac;
        int          a_val;
        int          b_val;
        for (int k = 0; k < N_POINTS; k++) begin
            quad  = ((4 * k) / N_POINTS) % 4;
            frac  = (longint'((4 * k) % N_POINTS) * 65536) / N_POINTS;
            a_val = quarter_wave_q15(frac);
            b_val = quarter_wave_q15(64'd65536 - frac);
            case (quad)
                0: begin sin_lut[k] = a_val;  cos_lut[k] = b_val;  end
                1: begin sin_lut[k] = b_val;  cos_lut[k] = -a_val; end
                2: begin sin_lut[k] = -a_val; cos_lut[k] = -b_val; end
                default: begin sin_lut[k] = -b_val; cos_lut[k] = a_val; end
            endcase
        end
        step_reg       = RADIUS_STEP_RESET;
        max_radius_reg = MAX_RADIUS_RESET;
        center_x_reg   = CENTER_RESET;
        center_y_reg   = CENTER_RESET;
        scan_angle     = 0;
        scan_radius    = int'(MAX_RADIUS_RESET);
        scan_outward   = 1'b0;
        scan_color     = COLOR_RED;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, plain point then restart
        queue_points(1, 1'b0, 0);
        queue_points(2, 1'b1, 0);
        wait_idle();

        // directed: centers on the rails, widest radius and step
        write_reg(REG_CENTER_X, 16'h0000);
        write_reg(REG_CENTER_Y, 16'hFFFF);
        write_reg(REG_MAX_RADIUS, 16'h7FFF);
        write_reg(REG_RADIUS_STEP, 16'h0FFF);
        queue_points(6, 1'b1, 0);
        wait_idle();

        // directed: opposite rails, zero radius and zero step
        write_reg(REG_CENTER_X, 16'hFFFF);
        write_reg(REG_CENTER_Y, 16'h0000);
        write_reg(REG_MAX_RADIUS, 16'h0000);
        write_reg(REG_RADIUS_STEP, 16'h0000);
        queue_points(6, 1'b1, 0);
        wait_idle();

        // random phases; registers change and phases with no leading restart carry the pattern over
        for (int phase = 0; phase < 6; phase++) begin
            send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            case (phase)
                0: begin
                    // small circles, random step and centers
                    write_reg(REG_MAX_RADIUS, 16'($urandom_range(50, 400)));
                    write_reg(REG_RADIUS_STEP, 16'($urandom_range(1, 300)));
                    write_reg(REG_CENTER_X, 16'($urandom_range(0, 65535)));
                    write_reg(REG_CENTER_Y, 16'($urandom_range(0, 65535)));
                    queue_points($urandom_range(60, 100), 1'b1, 400);
                end
                1: begin
                    // long receiver hold-off while points keep coming
                    stall_budget = stall_budget + 400;
                    write_reg(REG_RADIUS_STEP, 16'($urandom_range(100, 4095)));
                    queue_points($urandom_range(60, 100), 1'b0, 400);
                end
                2: begin
                    // zero step from zero radius flips at the circle end
                    write_reg(REG_MAX_RADIUS, 16'h0000);
                    write_reg(REG_RADIUS_STEP, 16'h0000);
                    queue_points(365, 1'b1, 0);
                end
                3: begin
                    // raw data, upper bits included
                    write_reg(REG_RADIUS_STEP, 16'($urandom_range(0, 65535)));
                    write_reg(REG_MAX_RADIUS, 16'($urandom_range(0, 65535)));
                    write_reg(REG_CENTER_X, 16'($urandom_range(0, 65535)));
                    write_reg(REG_CENTER_Y, 16'($urandom_range(0, 65535)));
                    queue_points($urandom_range(40, 80), 1'b0, 300);
                end
                4: begin
                    // largest radius on the rails, then a full step at the circle end
                    write_reg(REG_MAX_RADIUS, 16'h7FFF);
                    write_reg(REG_CENTER_X, 16'($urandom_range(0, 1) * 65535));
                    write_reg(REG_CENTER_Y, 16'($urandom_range(0, 1) * 65535));
                    queue_points(20, 1'b1, 0);
                    wait_idle();
                    write_reg(REG_MAX_RADIUS, 16'h0001);
                    write_reg(REG_RADIUS_STEP, 16'h0FFF);
                    queue_points($urandom_range(340, 360), 1'b0, 0);
                end
                default: begin
                    write_reg(REG_MAX_RADIUS, 16'($urandom_range(1, 32767)));
                    write_reg(REG_RADIUS_STEP, 16'($urandom_range(1, 4095)));
                    write_reg(REG_CENTER_X, 16'($urandom_range(0, 65535)));
                    write_reg(REG_CENTER_Y, 16'($urandom_range(0, 65535)));
                    queue_points($urandom_range(60, 100), 1'b1, 200);
                end
            endcase
            wait_idle();
        end

        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
